// File: rtl/wcs_pkg.sv
// Shared widths, the brush-side reset value and operation codes for the weighted cell sampler.
// No dependencies.
package wcs_pkg;

    localparam int BRUSH_SIDE_W = 7;
    localparam int WEIGHT_W     = 16;
    localparam int RANDOM_W     = 32;
    localparam int INDEX_W      = 12;
    localparam int COORD_W      = 6;

    localparam logic [BRUSH_SIDE_W-1:0] BRUSH_SIDE_RESET = 7'd16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

// File: rtl/weighted_cell_sampler_top.sv
// Weighted cell sampler top level: load/sample sequencer around the cumulative table.
// Depends on wcs_pkg and wcs_table.
//
// Usage:
//   Config: i_cfg_wr_en/i_cfg_wr_data set brush_side (0 acts as 1, above MAX_SIDE as
//   MAX_SIDE). Write only while no sample is in flight or pending at the output.
//   Input channel (i_in_valid / o_in_stall): a load item (operation 0) appends the
//   running weight sum to the table (when the grid has room), no result; first_cell
//   restarts it. Loads are taken every cycle while no sample is in progress. A sample
//   item (operation 1) yields one result item. A sample reads the total, then runs
//   S binary-search steps, where S is at most clog2(cells)+1 (13 for 4096 cells),
//   one table read per cycle, then D = clog2(MAX_SIDE+1) (7) restoring-divide steps
//   for row/column; with no cell loaded or a zero total it skips both. The next item
//   is taken on the same edge as the result can first be taken. The single table
//   read port sets the search rate.
//   Output channel (o_out_valid / i_out_stall): results sit in an output register,
//   so the next item is accepted while a result is stalled; a second sample result
//   waits in the sequencer until the register frees.
//   Reset (synchronous, active low) empties the table (pointer and total to zero),
//   sets brush_side to 16 and drops output valid. Table contents are not cleared.
module weighted_cell_sampler_top
    import wcs_pkg::*;
#(
    parameter int MAX_SIDE    = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int RANDOM_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [BRUSH_SIDE_W-1:0] i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic [WEIGHT_W-1:0]     i_weight,
    input  logic                    i_first_cell,
    input  logic [RANDOM_W-1:0]     i_random_word,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [INDEX_W-1:0]      o_cell_index,
    output logic [COORD_W-1:0]      o_column,
    output logic [COORD_W-1:0]      o_row,
    output logic                    o_empty_table
);

    localparam int CELL_CAP = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int CNT_W    = $clog2(CELL_CAP + 1);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int TOT_W    = WEIGHT_BITS + $clog2(CELL_CAP);
    localparam int W_USE    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int R_USE    = (RANDOM_BITS < RANDOM_W) ? RANDOM_BITS : RANDOM_W;
    localparam int PROD_W   = R_USE + TOT_W;
    localparam int DIV_W    = CNT_W + SIDE_W;
    localparam int BIT_W    = (SIDE_W > 1) ? $clog2(SIDE_W) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TOTAL  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // control state
    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_load_ptr, n_load_ptr;
    logic [TOT_W-1:0]        r_total, n_total;
    logic [BRUSH_SIDE_W-1:0] r_brush_side;
    logic                    r_out_valid, n_out_valid;

    // per-sample working registers
    logic [CNT_W-1:0]   r_n, n_n;
    logic [R_USE-1:0]   r_rand, n_rand;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [SIDE_W-1:0]  r_quo, n_quo;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_empty, n_empty;

    // output register payload
    logic [INDEX_W-1:0] r_o_idx, n_o_idx;
    logic [COORD_W-1:0] r_o_col, n_o_col;
    logic [COORD_W-1:0] r_o_row, n_o_row;
    logic               r_o_empty, n_o_empty;

    logic [SIDE_W-1:0]   side_eff;
    logic [2*SIDE_W-1:0] side_sq;
    logic [CNT_W-1:0]    cell_count;
    logic [CNT_W-1:0]    used_n;
    logic                in_acc;
    logic                out_free;
    logic [CNT_W-1:0]    base_ptr;
    logic [TOT_W-1:0]    base_tot;
    logic [TOT_W-1:0]    target;
    logic [CNT_W-1:0]    lo_nx, hi_nx, mid_nx;
    logic [CNT_W-1:0]    idx_sel;
    logic [DIV_W-1:0]    trial;

    logic               tbl_wr_en;
    logic [ADDR_W-1:0]  tbl_wr_addr;
    logic [TOT_W-1:0]   tbl_wr_data;
    logic [ADDR_W-1:0]  tbl_rd_addr;
    logic [TOT_W-1:0]   tbl_rd_data;

    wcs_table #(
        .ADDR_W (ADDR_W),
        .DATA_W (TOT_W)
    ) u_wcs_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    always_comb begin
        if (r_brush_side == '0) begin
            side_eff = SIDE_W'(1);
        end else if (32'(r_brush_side) > 32'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = SIDE_W'(r_brush_side);
        end
    end

    assign side_sq    = side_eff * side_eff;
    assign cell_count = CNT_W'(side_sq);
    assign used_n     = (r_load_ptr < cell_count) ? r_load_ptr : cell_count;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign base_ptr   = i_first_cell ? '0 : r_load_ptr;
    assign base_tot   = i_first_cell ? '0 : r_total;
    assign target     = TOT_W'(r_prod >> RANDOM_BITS);
    assign trial      = DIV_W'(side_eff) << r_bit;

    always_comb begin
        if (tbl_rd_data < target) begin
            lo_nx = r_mid + CNT_W'(1);
            hi_nx = r_hi;
        end else begin
            lo_nx = r_lo;
            hi_nx = r_mid;
        end
        mid_nx  = lo_nx + ((hi_nx - lo_nx) >> 1);
        idx_sel = (lo_nx < r_n) ? lo_nx : (r_n - CNT_W'(1));
    end

    always_comb begin
        n_state     = r_state;
        n_load_ptr  = r_load_ptr;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_n         = r_n;
        n_rand      = r_rand;
        n_prod      = r_prod;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_empty     = r_empty;
        n_o_idx     = r_o_idx;
        n_o_col     = r_o_col;
        n_o_row     = r_o_row;
        n_o_empty   = r_o_empty;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = ADDR_W'(base_ptr);
        tbl_wr_data = base_tot + TOT_W'(i_weight[W_USE-1:0]);
        tbl_rd_addr = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                tbl_rd_addr = ADDR_W'(used_n - CNT_W'(1));
                if (in_acc && i_operation == OP_LOAD) begin
                    n_load_ptr = base_ptr;
                    n_total    = base_tot;
                    if (base_ptr < cell_count) begin
                        tbl_wr_en  = 1'b1;
                        n_total    = tbl_wr_data;
                        n_load_ptr = base_ptr + CNT_W'(1);
                    end
                end else if (in_acc) begin
                    n_n    = used_n;
                    n_rand = i_random_word[R_USE-1:0];
                    if (used_n == '0) begin
                        n_empty = 1'b1;
                        n_idx   = '0;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_empty = 1'b0;
                        n_state = S_TOTAL;
                    end
                end
            end
            S_TOTAL: begin
                tbl_rd_addr = ADDR_W'(r_n >> 1);
                if (tbl_rd_data == '0) begin
                    n_empty = 1'b1;
                    n_idx   = '0;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_state = S_OUT;
                end else begin
                    n_prod  = PROD_W'(r_rand) * PROD_W'(tbl_rd_data);
                    n_lo    = '0;
                    n_hi    = r_n;
                    n_mid   = r_n >> 1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                tbl_rd_addr = ADDR_W'(mid_nx);
                n_lo  = lo_nx;
                n_hi  = hi_nx;
                n_mid = mid_nx;
                if (!(lo_nx < hi_nx)) begin
                    n_idx   = ADDR_W'(idx_sel);
                    n_rem   = DIV_W'(idx_sel);
                    n_quo   = '0;
                    n_bit   = BIT_W'(SIDE_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_quo = r_quo | (SIDE_W'(1) << r_bit);
                end
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_idx     = INDEX_W'(r_idx);
                    n_o_col     = COORD_W'(r_rem);
                    n_o_row     = COORD_W'(r_quo);
                    n_o_empty   = r_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_ptr   <= '0;
            r_total      <= '0;
            r_brush_side <= BRUSH_SIDE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_ptr  <= n_load_ptr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_brush_side <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_rand    <= n_rand;
        r_prod    <= n_prod;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_idx     <= n_idx;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_bit     <= n_bit;
        r_empty   <= n_empty;
        r_o_idx   <= n_o_idx;
        r_o_col   <= n_o_col;
        r_o_row   <= n_o_row;
        r_o_empty <= n_o_empty;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cell_index  = r_o_idx;
    assign o_column      = r_o_col;
    assign o_row         = r_o_row;
    assign o_empty_table = r_o_empty;

endmodule

// File: rtl/wcs_table.sv
// Cumulative-weight table storage: one write port, one read port, registered read.
// Standalone; no package dependencies.
module wcs_table #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 28
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/wcs_checker.sv
// Port-level checks for the weighted cell sampler, bound to the top level.
// Depends on wcs_pkg; sees only the top-level ports.
module wcs_checker
    import wcs_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_wr_en,
    input logic [BRUSH_SIDE_W-1:0] i_cfg_wr_data,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_operation,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [INDEX_W-1:0]      o_cell_index,
    input logic [COORD_W-1:0]      o_column,
    input logic [COORD_W-1:0]      o_row,
    input logic                    o_empty_table
);

    // effective side as last configured
    logic [8:0] r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 9'(BRUSH_SIDE_RESET);
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == '0) begin
                r_side <= 9'd1;
            end else if (32'(i_cfg_wr_data) > 32'(MAX_SIDE)) begin
                r_side <= 9'(MAX_SIDE);
            end else begin
                r_side <= 9'(i_cfg_wr_data);
            end
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_cell_index) && $stable(o_column)
            && $stable(o_row) && $stable(o_empty_table))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_table |->
            o_cell_index == '0 && o_column == '0 && o_row == '0)
        else $error("empty result carries a cell");

    a_coord_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_empty_table |-> (r_side > 9'd64) ||
            ((32'(o_column) < 32'(r_side)) &&
             (32'(o_row) * 32'(r_side) + 32'(o_column) == 32'(o_cell_index))))
        else $error("row/column disagree with cell index");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == OP_SAMPLE |=> o_in_stall)
        else $error("input taken during sample");

endmodule

bind weighted_cell_sampler_top wcs_checker #(.MAX_SIDE(MAX_SIDE)) u_wcs_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for weighted_cell_sampler_top: load/sample items with random
// idling and output stalls, results checked against a built-in cumulative-table predictor.
// Depends on wcs_pkg and the sampler RTL.
module tb;
    import wcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WIDE_CELLS   = 320;
    localparam int ITEM_GOAL    = 950;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_idx;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               empty;
    } t_draw;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [BRUSH_SIDE_W-1:0] i_cfg_wr_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_operation = OP_LOAD;
    logic [WEIGHT_W-1:0]     i_weight = '0;
    logic                    i_first_cell = 1'b0;
    logic [RANDOM_W-1:0]     i_random_word = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [INDEX_W-1:0]      o_cell_index;
    logic [COORD_W-1:0]      o_column;
    logic [COORD_W-1:0]      o_row;
    logic                    o_empty_table;

    weighted_cell_sampler_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_weight     (i_weight),
        .i_first_cell (i_first_cell),
        .i_random_word(i_random_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_index (o_cell_index),
        .o_column     (o_column),
        .o_row        (o_row),
        .o_empty_table(o_empty_table)
    );

    // predictor state
    logic [27:0]             cum_sum [0:CAP-1];
    int unsigned             fill_ptr = 0;
    logic [27:0]             weight_sum = '0;
    logic [BRUSH_SIDE_W-1:0] side_reg = BRUSH_SIDE_RESET;

    t_draw draw_q [$];
    bit    quiet = 1'b0;
    int    n_err = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_settings = 0;
    int    cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 14);
    end

    function automatic int unsigned grid_side();
        if (side_reg == 0) return 1;
        if (side_reg > 64) return 64;
        return 32'(side_reg);
    endfunction

    function automatic void apply_load(logic [WEIGHT_W-1:0] w, logic first_cell);
        int unsigned s;
        s = grid_side();
        if (first_cell) begin
            fill_ptr   = 0;
            weight_sum = '0;
        end
        if (fill_ptr < s * s) begin
            weight_sum                  = weight_sum + 28'(w);
            cum_sum[INDEX_W'(fill_ptr)] = weight_sum;
            fill_ptr++;
        end
    endfunction

    function automatic t_draw predict_draw(logic [RANDOM_W-1:0] rnd);
        int unsigned s, n, lo, hi, mid;
        logic [27:0] tot;
        logic [63:0] target;
        t_draw d;
        s   = grid_side();
        n   = (fill_ptr < s * s) ? fill_ptr : s * s;
        tot = (n > 0) ? cum_sum[INDEX_W'(n - 1)] : '0;
        d   = '0;
        if (n == 0 || tot == 0) begin
            d.empty = 1'b1;
        end else begin
            target = ({32'd0, rnd} * {36'd0, tot}) >> 32;
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if ({36'd0, cum_sum[INDEX_W'(mid)]} < target) lo = mid + 1;
                else hi = mid;
            end
            if (lo >= n) lo = n - 1;
            d.cell_idx = INDEX_W'(lo);
            d.col      = COORD_W'(lo % s);
            d.row      = COORD_W'(lo / s);
        end
        return d;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_draw e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (draw_q.size() == 0) begin
                $display("%0t: unexpected result cell_index %0d empty %0b",
                         $time, o_cell_index, o_empty_table);
                n_err++;
            end else begin
                e = draw_q.pop_front();
                n_checked++;
                if (o_cell_index !== e.cell_idx) begin
                    $display("%0t: cell_index expected %0d got %0d",
                             $time, e.cell_idx, o_cell_index);
                    n_err++;
                end
                if (o_column !== e.col) begin
                    $display("%0t: column expected %0d got %0d", $time, e.col, o_column);
                    n_err++;
                end
                if (o_row !== e.row) begin
                    $display("%0t: row expected %0d got %0d", $time, e.row, o_row);
                    n_err++;
                end
                if (o_empty_table !== e.empty) begin
                    $display("%0t: empty_table expected %0b got %0b",
                             $time, e.empty, o_empty_table);
                    n_err++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [WEIGHT_W-1:0] w, logic first_cell,
                             logic [RANDOM_W-1:0] rnd);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_weight      <= w;
        i_first_cell  <= first_cell;
        i_random_word <= rnd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        if (op == OP_LOAD) apply_load(w, first_cell);
        else draw_q.insert(draw_q.size(), predict_draw(rnd));
    endtask

    // drop valid, wait for every pending result, then let trailing loads finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (draw_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_side(logic [BRUSH_SIDE_W-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        side_reg = v;
        n_settings++;
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return '1;
            4:       return WEIGHT_W'($urandom_range(1, 3));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [RANDOM_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic sample(logic [RANDOM_W-1:0] rnd);
        send_item(OP_SAMPLE, WEIGHT_W'($urandom), 1'($urandom_range(0, 1)), rnd);
    endtask

    // empty table, zero total, zero-weight leading cell, load past the grid
    task automatic test_edge_cases();
        sample('1);
        set_side(7'd2);
        send_item(OP_LOAD, 16'd0, 1'b1, $urandom);
        sample('1);
        send_item(OP_LOAD, 16'hFFFF, 1'b0, $urandom);
        send_item(OP_LOAD, 16'd0, 1'b0, $urandom);
        send_item(OP_LOAD, 16'd1, 1'b0, $urandom);
        send_item(OP_LOAD, 16'd5, 1'b0, $urandom);
        sample('0);
        sample('1);
        sample(32'h8000_0000);
    endtask

    // side clamping both ways, table kept across side changes
    task automatic test_side_limits();
        set_side(7'd0);
        sample('1);
        set_side(7'd127);
        sample('1);
        sample(32'h0000_0001);
        set_side(7'd1);
        send_item(OP_LOAD, 16'hFFFF, 1'b1, $urandom);
        send_item(OP_LOAD, 16'd7, 1'b0, $urandom);
        sample($urandom);
        set_side(7'd64);
        sample('1);
    endtask

    // fill the first rows of the widest grid back to back, draw from both ends
    task automatic test_largest_grid();
        int i;
        logic [WEIGHT_W-1:0] w;
        set_side(7'd64);
        quiet = 1'b1;
        for (i = 0; i < WIDE_CELLS; i++) begin
            if (i == WIDE_CELLS - 1) w = '1;
            else if (i % 64 == 7) w = WEIGHT_W'($urandom);
            else w = WEIGHT_W'($urandom_range(0, 3));
            send_item(OP_LOAD, w, i == 0, $urandom);
        end
        sample('1);
        sample('0);
        repeat (6) sample($urandom);
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_random_sequences();
        int phase, cells, k, i;
        logic [BRUSH_SIDE_W-1:0] s;
        phase = 0;
        while (n_sent < ITEM_GOAL) begin
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       s = 7'd0;
                    1:       s = BRUSH_SIDE_W'($urandom_range(65, 127));
                    2:       s = 7'd64;
                    3:       s = BRUSH_SIDE_W'($urandom_range(9, 20));
                    default: s = BRUSH_SIDE_W'($urandom_range(1, 8));
                endcase
                set_side(s);
            end else if ($urandom_range(0, 1) != 0) begin
                settle();
            end
            cells = grid_side() * grid_side();
            if ($urandom_range(0, 3) != 0) begin
                k = $urandom_range(1, (cells < 40) ? cells + 2 : 40);
                for (i = 0; i < k; i++)
                    send_item(OP_LOAD, rand_weight(), i == 0, $urandom);
            end
            repeat ($urandom_range(2, 10)) begin
                if ($urandom_range(0, 99) < 15)
                    send_item(OP_LOAD, rand_weight(), $urandom_range(0, 7) == 0, $urandom);
                else
                    sample(rand_word());
            end
            phase++;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_side_limits();
        test_largest_grid();
        test_random_sequences();
        settle();
        if (draw_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, draw_q.size());
            n_err++;
        end
        $display("summary: %0d items sent, %0d results checked, %0d brush side writes",
                 n_sent, n_checked, n_settings);
        $display("summary: covered clamped sides, partial and overfilled tables, 64-wide grid");
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
